// ===== hdl/dfq_pkg.sv =====
`default_nettype none
package dfq_pkg;

  // built depth of the key chain
  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 7;
  localparam int OCC_W = 7;
  localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_SHUTDOWN = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_DUP   = 3'd1,
    STS_FULL  = 3'd2,
    STS_EMPTY = 3'd3,
    STS_SHUT  = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] middle;
    logic [31:0] lower;
  } key_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic cmp_en;  // capture compare result this cycle
    logic held;    // cell holds a live key
    logic wr;      // load the pushed key
    logic shift;   // take the neighbor's key (pop)
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/dfq_cell.sv =====
`default_nettype none
module dfq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dfq_pkg::cell_ctl_t ctl,
  input  dfq_pkg::key_t     cmp_key,
  input  dfq_pkg::key_t     push_key,
  input  dfq_pkg::key_t     next_key,
  output dfq_pkg::key_t     data,
  output logic              match
);
  import dfq_pkg::*;

  key_t data_r;
  key_t data_nxt;
  logic match_r;
  logic match_nxt;

  always_comb begin
    priority if (ctl.wr) begin
      data_nxt = push_key;
    end else if (ctl.shift) begin
      data_nxt = next_key;
    end else begin
      data_nxt = data_r;
    end
  end

  // only live cells may report a match
  assign match_nxt = ctl.cmp_en ? (ctl.held && (data_r == cmp_key)) : match_r;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule
`default_nettype wire

// ===== hdl/dedup_fifo_queue.sv =====
// timing: a command is taken into the command registers and the cell match flags, resolved
// in the exec state, and its result is then registered onto the out_ ports
// a new command is not taken until the last one is resolved (compare in the cells, then resolve and update)
// result is held on the out_ ports for one cycle with out_valid; the receiver cannot stall
// reset (rst_n low, synchronous): queue empty, shutdown cleared, counters zero,
// capacity 64; key storage is not cleared
`default_nettype none
module dedup_fifo_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [63:0]                in_key_upper,
  input  logic [63:0]                in_key_middle,
  input  logic [31:0]                in_key_lower,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [63:0]                out_upper,
  output logic [63:0]                out_middle,
  output logic [31:0]                out_lower,
  output logic [dfq_pkg::OCC_W-1:0]  out_occupancy,
  output logic [31:0]                out_push_attempts_total,
  output logic [31:0]                out_duplicates_total,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dfq_pkg::CAP_W-1:0]  cfg_data
);
  import dfq_pkg::*;

  // two-state sequencer: idle waits for a command, exec resolves it
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  opcode_t           op_r;
  key_t              key_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              shut_r, shut_nxt;
  logic [31:0]       attempts_r, attempts_nxt;
  logic [31:0]       dups_r, dups_nxt;
  logic [CAP_W-1:0]  cap_r;

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  key_t              okey_r, okey_nxt;

  logic              accept;
  logic              exec;
  logic              dup_hit;
  logic              full;
  logic              push_do;
  logic              pop_do;
  logic [WIDE_W-1:0] cap_wide;
  logic [WIDE_W-1:0] cap_eff;
  key_t              in_key;

  key_t              cell_data [DEPTH];
  logic [DEPTH-1:0]  match_vec;

  assign accept = start && !busy;
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;

  // capacity register transfer taken whenever no command is in flight
  assign cfg_ready = !busy;

  assign in_key.upper  = in_key_upper;
  assign in_key.middle = in_key_middle;
  assign in_key.lower  = in_key_lower;

  // any live cell holding the key flags a duplicate
  assign dup_hit = |match_vec;

  // capacity zero acts as one, above the built depth acts as the depth
  assign cap_wide = WIDE_W'(cap_r);
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = WIDE_W'(1);
    end else if (cap_wide > WIDE_W'(DEPTH)) begin
      cap_eff = WIDE_W'(DEPTH);
    end else begin
      cap_eff = cap_wide;
    end
  end
  assign full = WIDE_W'(count_r) >= cap_eff;

  assign push_do = exec && (op_r == OP_PUSH) && !dup_hit && !shut_r && !full;
  assign pop_do  = exec && (op_r == OP_POP) && (count_r != '0);

  // chain of key cells: cell 0 is the head, a pop moves every key one cell forward,
  // a push lands in the first free cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    key_t      nbr;

    assign ctl.cmp_en = accept;
    assign ctl.held   = (CNT_W'(i) < count_r);
    assign ctl.wr     = push_do && (CNT_W'(i) == count_r);
    assign ctl.shift  = pop_do;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    dfq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cmp_key  (in_key),
      .push_key (key_r),
      .next_key (nbr),
      .data     (cell_data[i]),
      .match    (match_vec[i])
    );
  end

  // resolve the command and update the queue state
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    shut_nxt     = shut_r;
    attempts_nxt = attempts_r;
    dups_nxt     = dups_r;
    status_nxt   = STS_OK;
    okey_nxt     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (op_r)
          OP_PUSH: begin
            attempts_nxt = attempts_r + 32'd1;
            priority if (dup_hit) begin
              dups_nxt   = dups_r + 32'd1;
              status_nxt = STS_DUP;
            end else if (shut_r) begin
              status_nxt = STS_SHUT;
            end else if (full) begin
              status_nxt = STS_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_POP: begin
            if (count_r == '0) begin
              status_nxt = STS_EMPTY;
            end else begin
              okey_nxt  = cell_data[0];
              count_nxt = count_r - CNT_W'(1);
            end
          end
          OP_SHUTDOWN: begin
            shut_nxt = 1'b1;
          end
          default: begin
            // unused code: nothing changes
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= in_key;
    end
    status_r <= status_nxt;
    okey_r   <= okey_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      shut_r      <= 1'b0;
      attempts_r  <= '0;
      dups_r      <= '0;
      cap_r       <= CAP_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      shut_r      <= shut_nxt;
      attempts_r  <= attempts_nxt;
      dups_r      <= dups_nxt;
      out_valid_r <= exec;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // counters and occupancy already reflect the finished command
  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_upper               = okey_r.upper;
  assign out_middle              = okey_r.middle;
  assign out_lower               = okey_r.lower;
  assign out_occupancy           = OCC_W'(count_r);
  assign out_push_attempts_total = attempts_r;
  assign out_duplicates_total    = dups_r;

endmodule
`default_nettype wire
